[design/assert_macros.svh]
// Assertion macros for the checker in wnps_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define WNPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define WNPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/wnps_pkg.sv]
// Shared types and constants of the nearest path point search.
package wnps_pkg;

    localparam int COORD_W = 24;
    localparam int IDX_W   = 11;
    localparam int ABS_W   = COORD_W + 1;
    localparam int DIST_W  = 2 * COORD_W + 2;

    typedef enum logic [1:0] {
        MODE_APPEND     = 2'd0,
        MODE_SEARCH_ALL = 2'd1,
        MODE_SEARCH_WIN = 2'd2,
        MODE_CLEAR      = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

endpackage

[design/windowed_nearest_path_point_search_top.sv]
// Top level of the windowed nearest path point search.
//
// An append or a clear strobes its result in the cycle after its start is
// taken; busy stays low, so one of these may be started every cycle. A search
// that answers without scanning (a whole path of at most one point, or a
// window start at or past the end) behaves the same way. A search that scans
// N stored points reads the point memory once per cycle and holds busy high
// while the reads pass the read register and the distance pipeline; its
// result strobes in the cycle busy falls. The store needs no clearing pass
// after reset: only entries below the fill count are ever read. Results
// cannot be held off and must be taken in the cycle o_valid is high.
module windowed_nearest_path_point_search_top
    import wnps_pkg::*;
#(
    parameter int PATH_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_mode,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic [IDX_W-1:0]          i_start_index,
    input  logic [IDX_W-1:0]          i_search_count,
    output logic                      o_valid,
    output logic [IDX_W-1:0]          o_closest_index,
    output logic                      o_status
);

    localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int SW = ((CW > IDX_W) ? CW : IDX_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_addr, r_last;
    logic signed [COORD_W-1:0] r_qx, r_qy;
    t_tag              r_rd_tag;
    logic [AW-1:0]     r_rd_idx;
    logic              r_have;
    logic [AW-1:0]     r_best_idx;
    logic [DIST_W-1:0] r_best_d;

    logic              accept;
    t_mode             mode;
    logic              full;
    logic              mem_we, mem_re;
    t_point            wdata, rdata;
    t_tag              d_tag;
    logic [AW-1:0]     d_idx;
    logic [DIST_W-1:0] d_dist;
    logic              take;
    logic [SW-1:0]     start_ext, pc_ext, win_sum, win_end;

    assign accept  = start && !busy;
    assign mode    = t_mode'(i_mode);
    assign full    = (r_count == CW'(PATH_DEPTH));
    assign busy    = (r_state != ST_IDLE);
    assign mem_we  = accept && (mode == MODE_APPEND) && !full;
    assign mem_re  = (r_state == ST_SCAN);
    assign wdata.x = i_point_x;
    assign wdata.y = i_point_y;
    assign take    = !r_have || (d_dist < r_best_d);

    assign start_ext = SW'(i_start_index);
    assign pc_ext    = SW'(r_count);
    assign win_sum   = start_ext + SW'(i_search_count);

    always_comb begin
        win_end = (win_sum > pc_ext) ? pc_ext : win_sum;
        if (win_end <= start_ext) begin
            win_end = start_ext + SW'(1);
        end
    end

    wnps_mem #(
        .DEPTH (PATH_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    wnps_dist #(
        .IW (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_idx   (r_rd_idx),
        .i_pt    (rdata),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_tag   (d_tag),
        .o_idx   (d_idx),
        .o_dist  (d_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_count         <= '0;
            r_rd_tag        <= '0;
            r_have          <= 1'b0;
            o_valid         <= 1'b0;
            o_closest_index <= '0;
            o_status        <= 1'b0;
        end else begin
            o_valid       <= 1'b0;
            r_rd_tag.vld  <= mem_re;
            r_rd_tag.last <= mem_re && (r_addr == r_last);
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        o_closest_index <= '0;
                        o_status        <= 1'b0;
                        case (mode)
                            MODE_APPEND: begin
                                o_valid  <= 1'b1;
                                o_status <= full;
                                if (!full) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            MODE_SEARCH_ALL: begin
                                if (r_count > CW'(1)) begin
                                    r_addr  <= '0;
                                    r_last  <= AW'(r_count - CW'(1));
                                    r_state <= ST_SCAN;
                                end else begin
                                    o_valid <= 1'b1;
                                end
                            end
                            MODE_SEARCH_WIN: begin
                                if (start_ext >= pc_ext) begin
                                    o_valid         <= 1'b1;
                                    o_closest_index <= IDX_W'(r_count);
                                end else begin
                                    r_addr  <= AW'(start_ext);
                                    r_last  <= AW'(win_end - SW'(1));
                                    r_state <= ST_SCAN;
                                end
                            end
                            MODE_CLEAR: begin
                                o_valid <= 1'b1;
                                r_count <= '0;
                            end
                            default: begin
                                o_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (r_addr == r_last) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                ST_DRAIN: begin
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (d_tag.vld) begin
                if (d_tag.last) begin
                    r_have          <= 1'b0;
                    o_valid         <= 1'b1;
                    o_closest_index <= IDX_W'(take ? d_idx : r_best_idx);
                    r_state         <= ST_IDLE;
                end else begin
                    r_have <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (accept) begin
            r_qx <= i_point_x;
            r_qy <= i_point_y;
        end
        if (d_tag.vld && take) begin
            r_best_d   <= d_dist;
            r_best_idx <= d_idx;
        end
    end

endmodule

[design/wnps_mem.sv]
// Point store: one write port, one registered read port.
module wnps_mem
    import wnps_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_point        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_point        o_rdata
);

    t_point r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[design/wnps_dist.sv]
// Three-stage squared distance pipeline with index and tag carried along.
module wnps_dist
    import wnps_pkg::*;
#(
    parameter int IW = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_tag                      i_tag,
    input  logic [IW-1:0]             i_idx,
    input  t_point                    i_pt,
    input  logic signed [COORD_W-1:0] i_qx,
    input  logic signed [COORD_W-1:0] i_qy,
    output t_tag                      o_tag,
    output logic [IW-1:0]             o_idx,
    output logic [DIST_W-1:0]         o_dist
);

    t_tag                r_tag1, r_tag2;
    logic [IW-1:0]       r_idx1, r_idx2;
    logic [ABS_W-1:0]    r_ax, r_ay;
    logic [DIST_W-1:0]   r_sqx, r_sqy;
    logic signed [ABS_W-1:0] dx, dy;

    assign dx = ABS_W'(i_pt.x) - ABS_W'(i_qx);
    assign dy = ABS_W'(i_pt.y) - ABS_W'(i_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            o_tag  <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            o_tag  <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_ax   <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
        r_ay   <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
        r_idx2 <= r_idx1;
        r_sqx  <= DIST_W'(r_ax) * DIST_W'(r_ax);
        r_sqy  <= DIST_W'(r_ay) * DIST_W'(r_ay);
        o_idx  <= r_idx2;
        o_dist <= r_sqx + r_sqy;
    end

endmodule

[design/wnps_chk.sv]
// Port-level checker for the nearest path point search, bound to the top level.
`include "assert_macros.svh"

module wnps_chk
    import wnps_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [1:0]                i_mode,
    input logic signed [COORD_W-1:0] i_point_x,
    input logic signed [COORD_W-1:0] i_point_y,
    input logic [IDX_W-1:0]          i_start_index,
    input logic [IDX_W-1:0]          i_search_count,
    input logic                      o_valid,
    input logic [IDX_W-1:0]          o_closest_index,
    input logic                      o_status
);

    logic       accept;
    logic [1:0] r_pend;
    t_mode      r_mode;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_mode <= MODE_APPEND;
        end else begin
            r_pend <= r_pend + 2'(accept) - 2'(o_valid);
            if (accept) begin
                r_mode <= t_mode'(i_mode);
            end
        end
    end

    `WNPS_ASSERT(a_no_spurious_result, i_clk, i_rst_n, o_valid |-> (r_pend != 2'd0), "result without transaction")
    `WNPS_ASSERT(a_busy_has_work, i_clk, i_rst_n, busy |-> (r_pend == 2'd1), "busy without one open transaction")
    `WNPS_ASSERT(a_quick_result, i_clk, i_rst_n, (accept && (i_mode == MODE_APPEND || i_mode == MODE_CLEAR)) |=> (o_valid && !busy), "append or clear result late")
    `WNPS_ASSERT_NEVER(a_status_append_only, i_clk, i_rst_n, o_valid && o_status && (r_mode != MODE_APPEND), "status set outside append")

endmodule

bind windowed_nearest_path_point_search_top wnps_chk u_wnps_chk (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the windowed nearest path point search top level.
module testbench;
    import wnps_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 400;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
    localparam logic [IDX_W-1:0]          IDX_TOP   = 11'd1024;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             status;
    } t_answer;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                i_mode;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic [IDX_W-1:0]          i_start_index;
    logic [IDX_W-1:0]          i_search_count;
    logic                      o_valid;
    logic [IDX_W-1:0]          o_closest_index;
    logic                      o_status;

    logic signed [COORD_W-1:0] path_x [DEPTH];
    logic signed [COORD_W-1:0] path_y [DEPTH];
    int                        stored_points = 0;
    t_answer                   expected_answers [$];
    int                        errors = 0;
    int                        cycle_count = 0;
    int                        sent_items = 0;
    bit                        gaps_on = 1'b1;

    windowed_nearest_path_point_search_top #(
        .PATH_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_start_index  (i_start_index),
        .i_search_count (i_search_count),
        .o_valid        (o_valid),
        .o_closest_index(o_closest_index),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint sq_distance(int idx, longint qx, longint qy);
        longint dx;
        longint dy;
        dx = longint'(path_x[idx]) - qx;
        dy = longint'(path_y[idx]) - qy;
        return dx * dx + dy * dy;
    endfunction

    // strict compare: earliest point wins a tie
    function automatic int nearest_in_range(int first, int stop, longint qx, longint qy);
        int     best;
        longint best_d;
        longint d;
        best   = first;
        best_d = sq_distance(first, qx, qy);
        for (int i = first + 1; i < stop; i++) begin
            d = sq_distance(i, qx, qy);
            if (d < best_d) begin
                best_d = d;
                best   = i;
            end
        end
        return best;
    endfunction

    function automatic t_answer search_path(t_mode mode, logic signed [COORD_W-1:0] x,
                                            logic signed [COORD_W-1:0] y,
                                            logic [IDX_W-1:0] first, logic [IDX_W-1:0] span);
        t_answer ans;
        int      stop;
        ans = '0;
        case (mode)
            MODE_APPEND: begin
                if (stored_points >= DEPTH) begin
                    ans.status = 1'b1;
                end else begin
                    path_x[stored_points] = x;
                    path_y[stored_points] = y;
                    stored_points++;
                end
            end
            MODE_SEARCH_ALL: begin
                if (stored_points > 1)
                    ans.index = IDX_W'(nearest_in_range(0, stored_points, x, y));
            end
            MODE_SEARCH_WIN: begin
                if (int'(first) >= stored_points) begin
                    ans.index = IDX_W'(stored_points);
                end else begin
                    stop = int'(first) + int'(span);
                    if (stop > stored_points)
                        stop = stored_points;
                    if (stop <= int'(first))
                        stop = int'(first) + 1;
                    ans.index = IDX_W'(nearest_in_range(int'(first), stop, x, y));
                end
            end
            default: begin
                stored_points = 0;
            end
        endcase
        return ans;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] c,
                                                             int spread);
        return COORD_W'(int'(c) + int'($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic send_cmd(t_mode mode, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y,
                            logic [IDX_W-1:0] first, logic [IDX_W-1:0] span);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(99) < 12) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_mode         <= mode;
        i_point_x      <= x;
        i_point_y      <= y;
        i_start_index  <= first;
        i_search_count <= span;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_answers.push_back(search_path(mode, x, y, first, span));
        sent_items++;
    endtask

    task automatic quiet_bus();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        quiet_bus();
        while (expected_answers.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_path();
        send_cmd(MODE_SEARCH_ALL, 0, 0, 0, 0);
        send_cmd(MODE_SEARCH_WIN, rand_coord(), rand_coord(), 0, 5);
        send_cmd(MODE_SEARCH_WIN, rand_coord(), rand_coord(), IDX_TOP, IDX_TOP);
        send_cmd(MODE_APPEND, 5, -5, 0, 0);
        send_cmd(MODE_SEARCH_ALL, COORD_MAX, COORD_MIN, 0, 0);
        send_cmd(MODE_SEARCH_WIN, 1, 1, 0, 0);
        send_cmd(MODE_SEARCH_WIN, 1, 1, 1, 3);
    endtask

    task automatic test_extremes();
        send_cmd(MODE_CLEAR, rand_coord(), rand_coord(), IDX_TOP, IDX_TOP);
        send_cmd(MODE_APPEND, COORD_MAX, COORD_MAX, 0, 0);
        send_cmd(MODE_APPEND, COORD_MIN, COORD_MIN, 0, 0);
        send_cmd(MODE_APPEND, 0, 0, 0, 0);
        send_cmd(MODE_APPEND, COORD_MAX, COORD_MIN, 0, 0);
        send_cmd(MODE_APPEND, COORD_MIN, COORD_MAX, 0, 0);
        send_cmd(MODE_APPEND, 0, 0, 0, 0);
        send_cmd(MODE_APPEND, 7, -3, IDX_TOP, IDX_TOP);
        send_cmd(MODE_SEARCH_ALL, COORD_MIN, COORD_MIN, 0, 0);
        send_cmd(MODE_SEARCH_ALL, COORD_MAX, COORD_MAX, 0, 0);
        send_cmd(MODE_SEARCH_ALL, 0, 0, 0, 0);
        send_cmd(MODE_SEARCH_ALL, COORD_MAX, COORD_MIN, 0, 0);
        send_cmd(MODE_SEARCH_ALL, 4, -1, 0, 0);
        send_cmd(MODE_SEARCH_WIN, COORD_MIN, COORD_MIN, 3, 0);
        send_cmd(MODE_SEARCH_WIN, COORD_MIN, COORD_MIN, 3, 1);
        send_cmd(MODE_SEARCH_WIN, COORD_MIN, COORD_MAX, 1, IDX_TOP);
        send_cmd(MODE_SEARCH_WIN, 0, 0, 2, 5);
        send_cmd(MODE_SEARCH_WIN, 0, 0, 7, 2);
        send_cmd(MODE_SEARCH_WIN, 0, 0, IDX_TOP, 1);
        send_cmd(MODE_SEARCH_WIN, 0, 0, 11'd1023, IDX_TOP);
        send_cmd(MODE_SEARCH_WIN, 0, 0, 5, 2);
    endtask

    task automatic test_full_store();
        wait_drained();
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < DEPTH; i++)
            send_cmd(MODE_APPEND, rand_coord(), rand_coord(), 0, 0);
        send_cmd(MODE_APPEND, COORD_MAX, COORD_MAX, 0, 0);
        send_cmd(MODE_APPEND, COORD_MIN, COORD_MIN, IDX_TOP, IDX_TOP);
        send_cmd(MODE_SEARCH_ALL, rand_coord(), rand_coord(), 0, 0);
        send_cmd(MODE_SEARCH_ALL, path_x[700], path_y[700], 0, 0);
        send_cmd(MODE_SEARCH_WIN, rand_coord(), rand_coord(), 1000, IDX_TOP);
        send_cmd(MODE_SEARCH_WIN, rand_coord(), rand_coord(), IDX_TOP, 1);
        send_cmd(MODE_SEARCH_WIN, rand_coord(), rand_coord(), 0, IDX_TOP);
        send_cmd(MODE_SEARCH_WIN, rand_coord(), rand_coord(), 11'd1023, 0);
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        send_cmd(MODE_SEARCH_ALL, 0, 0, 0, 0);
    endtask

    task automatic test_random_paths();
        int                        first_item;
        int                        pick;
        int                        spread;
        int                        span_max;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [IDX_W-1:0]          first;
        logic [IDX_W-1:0]          span;
        first_item = sent_items;
        while (sent_items - first_item < RANDOM_ITEMS) begin
            gaps_on = !(sent_items - first_item >= 150 && sent_items - first_item < 250);
            pick = $urandom_range(99);
            if (pick < 80) begin
                if (stored_points > 150 || $urandom_range(3) == 0)
                    send_cmd(MODE_CLEAR, rand_coord(), rand_coord(),
                             IDX_W'($urandom_range(1024)), IDX_W'($urandom_range(1024)));
                case ($urandom_range(2))
                    0:       spread = 4;
                    1:       spread = 1000;
                    default: spread = 1 << 22;
                endcase
                cx = rand_coord();
                cy = rand_coord();
                px = near_coord(cx, spread);
                py = near_coord(cy, spread);
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(5) != 0) begin
                        px = near_coord(cx, spread);
                        py = near_coord(cy, spread);
                    end
                    send_cmd(MODE_APPEND, px, py, 0, 0);
                end
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(3) == 0) begin
                        px = rand_coord();
                        py = rand_coord();
                    end else begin
                        px = near_coord(cx, spread);
                        py = near_coord(cy, spread);
                    end
                    span_max = stored_points + 2;
                    first = IDX_W'($urandom_range(span_max));
                    span  = IDX_W'($urandom_range(span_max));
                    if ($urandom_range(15) == 0)
                        span = IDX_TOP;
                    if ($urandom_range(2) == 0)
                        send_cmd(MODE_SEARCH_ALL, px, py, first, span);
                    else
                        send_cmd(MODE_SEARCH_WIN, px, py, first, span);
                end
            end else begin
                send_cmd(t_mode'($urandom_range(3)), rand_coord(), rand_coord(),
                         IDX_W'($urandom_range(1024)), IDX_W'($urandom_range(1024)));
            end
            if ($urandom_range(19) == 0)
                wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected transaction: index %0d status %0d", $time,
                         o_closest_index, o_status);
                errors++;
            end else begin
                want = expected_answers.pop_front();
                if (o_closest_index !== want.index) begin
                    $display("%0t: closest_index expected %0d actual %0d", $time,
                             want.index, o_closest_index);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d transactions pending", $time, expected_answers.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = MODE_APPEND;
        i_point_x      = '0;
        i_point_y      = '0;
        i_start_index  = '0;
        i_search_count = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_path();
        test_extremes();
        test_full_store();
        test_random_paths();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
